[rtl/psg_pkg.sv]
`timescale 1ns / 1ps

package psg_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_PAGE_SIZE_LOG2 = 2'd0;
    localparam logic [1:0] REG_LIST_MODE      = 2'd1;
    localparam logic [1:0] REG_MAX_SEGMENTS   = 2'd2;

    localparam int ADDR_W = 64;
    localparam int LEN_W  = 34;
    localparam int CNT_W  = 13;
    localparam int LG_W   = 5;

    localparam logic [LG_W-1:0]  PAGE_LOG2_MIN   = 5'd9;
    localparam logic [LG_W-1:0]  PAGE_LOG2_MAX   = 5'd21;
    localparam logic [LG_W-1:0]  PAGE_LOG2_RESET = 5'd12;
    localparam logic [CNT_W-1:0] LIST_CAP        = 13'd4096;
    localparam logic [CNT_W-1:0] COUNT_CAP       = 13'd8191;
    localparam logic [LEN_W-1:0] LEN_CAP         = 34'h2_0000_0000;

    // Result kinds.
    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    typedef struct packed {
        logic [LG_W-1:0]  page_size_log2;
        logic             list_mode;
        logic [CNT_W-1:0] max_segments;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [CNT_W-1:0]  total;
        logic              last;
    } result_t;

    // Up to two results caused by one page, in delivery order.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

[rtl/page_run_sg_coalescer.sv]
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------------
// in       | in_valid / in_ready    | page_address, last_page
// out      | out_valid / out_ready  | result_kind, seg_address, seg_length,
//          |                        | seg_total, seg_last
// cfg      | cfg_write (no stall)   | cfg_index, cfg_data
//
// A page transfer is registered; once the queue has room the held page is merged
// into the pass state and its results are written into a four-entry result queue
// at the same edge, and the first result is offered straight from the queue.
// One page is taken every cycle while the queue holds at most two results; a page
// that closes a segment and ends the pass makes two results, which drain one per
// cycle through the output port while out_ready is high.
// Reset is asynchronous and restores the register defaults and an empty pass; no
// clearing pass is needed. Output stalls back up through the queue into the input.
module page_run_sg_coalescer
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [psg_pkg::CNT_W-1:0]  cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [psg_pkg::ADDR_W-1:0] page_address,
    input  logic                       last_page,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       result_kind,
    output logic [psg_pkg::ADDR_W-1:0] seg_address,
    output logic [psg_pkg::LEN_W-1:0]  seg_length,
    output logic [psg_pkg::CNT_W-1:0]  seg_total,
    output logic                       seg_last
);

    psg_pkg::cfg_t              cfg_reg;
    logic                       in_valid_reg;
    logic [psg_pkg::ADDR_W-1:0] addr_reg;
    logic                       last_reg;
    logic                       advance;
    logic                       room;
    psg_pkg::push_t             push;
    psg_pkg::result_t           head;

    // The held page moves into the pass state once the queue can take both of
    // its possible results.
    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_size_log2 <= psg_pkg::PAGE_LOG2_RESET;
            cfg_reg.list_mode      <= 1'b0;
            cfg_reg.max_segments   <= psg_pkg::LIST_CAP;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                psg_pkg::REG_PAGE_SIZE_LOG2:
                begin
                    cfg_reg.page_size_log2 <= cfg_data[psg_pkg::LG_W-1:0];
                end
                psg_pkg::REG_LIST_MODE:
                begin
                    cfg_reg.list_mode <= cfg_data[0];
                end
                psg_pkg::REG_MAX_SEGMENTS:
                begin
                    cfg_reg.max_segments <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Page payload is held with the valid flag and needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            addr_reg <= page_address;
            last_reg <= last_page;
        end
    end

    psg_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .addr    (addr_reg),
        .last    (last_reg),
        .cfg     (cfg_reg),
        .push    (push)
    );

    psg_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_ready),
        .room      (room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign result_kind = head.kind;
    assign seg_address = head.address;
    assign seg_length  = head.length;
    assign seg_total   = head.total;
    assign seg_last    = head.last;

endmodule

[rtl/psg_core.sv]
`timescale 1ns / 1ps

module psg_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [psg_pkg::ADDR_W-1:0]  addr,
    input  logic                        last,
    input  psg_pkg::cfg_t               cfg,
    output psg_pkg::push_t              push
);

    logic [psg_pkg::ADDR_W-1:0] prev_address_reg;
    logic [psg_pkg::ADDR_W-1:0] run_start_reg;
    logic [psg_pkg::LEN_W-1:0]  run_length_reg;
    logic [psg_pkg::CNT_W-1:0]  segments_seen_reg;
    logic                       first_pending_reg;
    logic                       first_emitted_reg;

    logic [psg_pkg::ADDR_W-1:0] run_start_next;
    logic [psg_pkg::LEN_W-1:0]  run_length_next;
    logic [psg_pkg::CNT_W-1:0]  segments_seen_next;
    logic                       first_emitted_next;

    logic [psg_pkg::LG_W-1:0]   lg;
    logic [21:0]                ps;
    logic [21:0]                offset_mask;
    logic [psg_pkg::CNT_W-1:0]  limit;
    logic                       contiguous;
    logic                       new_run;
    logic [psg_pkg::LEN_W:0]    len_sum;
    logic [psg_pkg::LEN_W-1:0]  len_grown;
    logic [21:0]                off_a;
    logic [21:0]                off_b;
    logic [psg_pkg::CNT_W-1:0]  idx_a;
    logic [psg_pkg::CNT_W-1:0]  idx_b;
    logic                       emit_a;
    logic                       emit_b;
    logic [psg_pkg::LEN_W-1:0]  len_a;
    logic [psg_pkg::LEN_W-1:0]  len_b;
    psg_pkg::result_t           res_a;
    psg_pkg::result_t           res_b;

    always_comb
    begin
        if (cfg.page_size_log2 < psg_pkg::PAGE_LOG2_MIN)
        begin
            lg = psg_pkg::PAGE_LOG2_MIN;
        end
        else if (cfg.page_size_log2 > psg_pkg::PAGE_LOG2_MAX)
        begin
            lg = psg_pkg::PAGE_LOG2_MAX;
        end
        else
        begin
            lg = cfg.page_size_log2;
        end
        ps          = 22'd1 << lg;
        offset_mask = ps - 22'd1;
        limit       = (cfg.max_segments < psg_pkg::LIST_CAP) ? cfg.max_segments
                                                             : psg_pkg::LIST_CAP;

        contiguous = ((prev_address_reg + psg_pkg::ADDR_W'(ps)) == addr);
        new_run    = first_pending_reg || !contiguous;

        // A break in contiguity closes the running segment.
        idx_a  = segments_seen_reg - 13'd1;
        emit_a = !first_pending_reg && !contiguous && cfg.list_mode && (idx_a < limit);
        off_a  = run_start_reg[21:0] & offset_mask;
        if (first_emitted_reg)
        begin
            len_a = run_length_reg;
        end
        else if (run_length_reg >= psg_pkg::LEN_W'(off_a))
        begin
            len_a = run_length_reg - psg_pkg::LEN_W'(off_a);
        end
        else
        begin
            len_a = '0;
        end
        res_a.kind    = psg_pkg::KIND_SEGMENT;
        res_a.address = run_start_reg;
        res_a.length  = len_a;
        res_a.total   = idx_a;
        res_a.last    = (({1'b0, idx_a} + 14'd1) == {1'b0, limit});

        // Pass state after this page is merged or opens a new run.
        len_sum   = {1'b0, run_length_reg} + (psg_pkg::LEN_W + 1)'(ps);
        len_grown = (len_sum > {1'b0, psg_pkg::LEN_CAP}) ? psg_pkg::LEN_CAP
                                                         : len_sum[psg_pkg::LEN_W-1:0];
        if (new_run)
        begin
            run_start_next  = addr;
            run_length_next = psg_pkg::LEN_W'(ps);
            segments_seen_next = (segments_seen_reg < psg_pkg::COUNT_CAP)
                               ? segments_seen_reg + 13'd1 : segments_seen_reg;
        end
        else
        begin
            run_start_next     = run_start_reg;
            run_length_next    = len_grown;
            segments_seen_next = segments_seen_reg;
        end
        first_emitted_next = first_emitted_reg || emit_a;

        // The last page closes the pass with a segment (in list mode, while under the limit) or the count.
        idx_b = segments_seen_next - 13'd1;
        off_b = run_start_next[21:0] & offset_mask;
        if (first_emitted_next)
        begin
            len_b = run_length_next;
        end
        else if (run_length_next >= psg_pkg::LEN_W'(off_b))
        begin
            len_b = run_length_next - psg_pkg::LEN_W'(off_b);
        end
        else
        begin
            len_b = '0;
        end
        if (cfg.list_mode)
        begin
            emit_b        = last && (idx_b < limit);
            res_b.kind    = psg_pkg::KIND_SEGMENT;
            res_b.address = run_start_next;
            res_b.length  = len_b;
            res_b.total   = idx_b;
        end
        else
        begin
            emit_b        = last;
            res_b.kind    = psg_pkg::KIND_COUNT;
            res_b.address = '0;
            res_b.length  = '0;
            res_b.total   = segments_seen_next;
        end
        res_b.last = 1'b1;

        push.valid0 = advance && (emit_a || emit_b);
        push.valid1 = advance && emit_a && emit_b;
        push.res0   = emit_a ? res_a : res_b;
        push.res1   = res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_address_reg  <= '0;
            run_start_reg     <= '0;
            run_length_reg    <= '0;
            segments_seen_reg <= '0;
            first_pending_reg <= 1'b1;
            first_emitted_reg <= 1'b0;
        end
        else if (advance)
        begin
            prev_address_reg <= addr;
            if (last)
            begin
                run_start_reg     <= '0;
                run_length_reg    <= '0;
                segments_seen_reg <= '0;
                first_pending_reg <= 1'b1;
                first_emitted_reg <= 1'b0;
            end
            else
            begin
                run_start_reg     <= run_start_next;
                run_length_reg    <= run_length_next;
                segments_seen_reg <= segments_seen_next;
                first_pending_reg <= 1'b0;
                first_emitted_reg <= first_emitted_next;
            end
        end
    end

    // A pass that has begun always counts at least its open segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        !first_pending_reg |-> segments_seen_reg != '0)
        else $error("open pass with zero segments");

    assert property (@(posedge clk) disable iff (!rst_n)
        first_pending_reg |-> (segments_seen_reg == '0) && !first_emitted_reg)
        else $error("idle pass state not cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> first_pending_reg)
        else $error("pass did not close after the last page");

endmodule

[rtl/psg_fifo.sv]
`timescale 1ns / 1ps

module psg_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  psg_pkg::push_t   push,
    input  logic             pop,
    output logic             room,
    output logic             not_empty,
    output psg_pkg::result_t head
);

    psg_pkg::result_t entry_reg [4];
    logic [1:0]       wr_ptr_reg;
    logic [1:0]       rd_ptr_reg;
    logic [2:0]       count_reg;
    logic             do_pop;
    logic [2:0]       n_push;

    assign not_empty = (count_reg != 3'd0);
    assign room      = (count_reg <= 3'd2);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;
    assign n_push    = {2'b00, push.valid0} + {2'b00, push.valid1};

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push[1:0];
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + n_push - {2'b00, do_pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0 && room)
        else $error("second result pushed without room or first");

endmodule
